// File: design/madenv_pkg.sv
// Shared types, constants and register codes of the attack-decay envelope unit.
`default_nettype none

package madenv_pkg;

	// Field and sample widths
	localparam int SAMPLE_W   = 24;
	localparam int FRAC_W     = 20;
	localparam int CHAN_W     = 4;
	localparam int OUT_W      = 22;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;
	localparam int RATE_W     = 18;
	localparam int ACT_W      = 5;

	// Coefficients are unsigned Q1.22, at most 1.0
	localparam int COEF_FRAC = 22;
	localparam int COEF_W    = COEF_FRAC + 1;
	localparam int MIN_COUNT = 8;
	localparam int COEF_NUM  = MIN_COUNT << COEF_FRAC;

	// Attack margin: 0.0018 per second of attack, in Q3.20, saturated
	localparam int MARGIN_W   = SAMPLE_W - 1;
	localparam int RATE_SCALE = 10000;
	localparam logic [MARGIN_W-1:0] MARGIN_MAX = '1;

	// Switch threshold: 999/1000 of the target, rounded half up
	localparam int THR_NUM  = 999;
	localparam int THR_DEN  = 1000;
	localparam int THR_HALF = 500;

	// Shared serial divider
	localparam int DIV_NUM_W = 50;
	localparam int DIV_DEN_W = 32;
	localparam int DIV_CNT_W = $clog2(DIV_NUM_W + 1);

	// Register reset values
	localparam logic [CFG_DATA_W-1:0]        ATTACK_RST = 24'd1323;
	localparam logic [CFG_DATA_W-1:0]        DECAY_RST  = 24'd44100;
	localparam logic [RATE_W-1:0]            RATE_RST   = 18'd44100;
	localparam logic signed [SAMPLE_W-1:0]   AMP_RST    = 24'sh100000;
	localparam logic [ACT_W-1:0]             ACTIVE_RST = 5'd2;

	// Register indexes of the configuration port
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ATTACK = 3'd0,
		REG_DECAY  = 3'd1,
		REG_RATE   = 3'd2,
		REG_AMP    = 3'd3,
		REG_ACTIVE = 3'd4
	} cfg_reg_t;

	// Coefficient derivation sequencer
	typedef enum logic [2:0] {
		DRV_IDLE,
		DRV_SETUP,
		DRV_ATK_GO,
		DRV_ATK_WAIT,
		DRV_DEC_GO,
		DRV_DEC_WAIT,
		DRV_MRG_GO,
		DRV_MRG_WAIT
	} drv_state_t;

	// Per-item sequencer of the channel datapath
	typedef enum logic [1:0] {
		CS_IDLE,
		CS_MUL,
		CS_UPD,
		CS_WB
	} core_state_t;

	// One entry of the channel state memory
	typedef struct packed {
		logic signed [SAMPLE_W-1:0] level;
		logic signed [SAMPLE_W-1:0] held;
		logic                       in_decay;
		logic                       prev_gate;
	} chan_state_t;

	localparam chan_state_t CHAN_RESET = '{level: '0, held: '0, in_decay: 1'b1,
		prev_gate: 1'b0};

	// Settings handed from the register block to the datapath
	typedef struct packed {
		logic signed [SAMPLE_W-1:0] amp;
		logic [ACT_W-1:0]           active;
		logic [COEF_W-1:0]          atk_coeff;
		logic [COEF_W-1:0]          dec_coeff;
		logic [MARGIN_W-1:0]        margin;
		logic                       busy;
	} cfg_bus_t;

	// Divider request and response
	typedef struct packed {
		logic                 start;
		logic [DIV_NUM_W-1:0] num;
		logic [DIV_DEN_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic                 done;
		logic [DIV_NUM_W-1:0] quo;
	} div_rsp_t;

endpackage

`default_nettype wire

// File: design/madenv_ifs.sv
// Valid-ready channel interfaces for envelope ticks and envelope results.
`default_nettype none

interface madenv_tick_if import madenv_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic [CHAN_W-1:0]          channel;
	logic                       gate;
	logic signed [SAMPLE_W-1:0] velocity;

	modport source (output valid, output channel, output gate, output velocity,
		input ready);
	modport sink (input valid, input channel, input gate, input velocity,
		output ready);
endinterface

interface madenv_result_if import madenv_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic [CHAN_W-1:0]       out_channel;
	logic signed [OUT_W-1:0] envelope_out;

	modport source (output valid, output out_channel, output envelope_out,
		input ready);
	modport sink (input valid, input out_channel, input envelope_out,
		output ready);
endinterface

`default_nettype wire

// File: design/multichannel_attack_decay_envelope_unit.sv
// Top level of the multichannel attack-decay envelope unit.
//
// Each item on the tick channel is one sample tick of one channel: a channel
// number, a gate bit and a velocity in signed Q3.20. Every tick of a channel
// in use gives one item on the result channel: the channel and the envelope
// times the amplitude, clipped to plus or minus one. Ticks for channels at or
// above the active channel count or MAX_CHANNELS are taken and give no result.
// The per-channel state sits in a single-port-write memory that each item
// reads, updates and writes back, so one item is in flight at a time: a tick
// is taken only once the previous item has passed the multiply, update and
// write-back states of the read-multiply-update-write round trip.
// Configuration arrives on the write port (wr_en, wr_index, wr_data). After
// reset, and after each write of the attack length, decay length or sample
// rate, a serial divider rederives both coefficients and the attack margin;
// tick.ready stays low meanwhile.
// Reset clears every channel to level zero in decay, gate low.
// A stalled receiver holds the result steady; one further result waits in a
// finishing stage, and ticks are then taken until that stage is needed again.
`default_nettype none

module multichannel_attack_decay_envelope_unit import madenv_pkg::*; #(
	parameter int MAX_CHANNELS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  logic [CFG_IDX_W-1:0]  wr_index,
	input  logic [CFG_DATA_W-1:0] wr_data,
	madenv_tick_if.sink           tick,
	madenv_result_if.source       result
);

	cfg_bus_t cfg;

	// Registers and coefficient derivation
	madenv_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.cfg      (cfg)
	);

	// Channel state memory and envelope datapath
	madenv_core #(
		.MAX_CHANNELS (MAX_CHANNELS)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.tick   (tick),
		.result (result)
	);

endmodule

`default_nettype wire

// File: design/madenv_div.sv
// Restoring radix-2 divider, one quotient bit per cycle, shared by both coefficients and the margin.
`default_nettype none

module madenv_div import madenv_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic [DIV_NUM_W-1:0] quo_q;
	logic [DIV_DEN_W-1:0] rem_q;
	logic [DIV_DEN_W-1:0] den_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [DIV_DEN_W:0]   trial;
	logic [DIV_DEN_W:0]   diff;
	logic                 fits;

	// Shift the next numerator bit into the partial remainder and try a subtract.
	assign trial = {rem_q, quo_q[DIV_NUM_W-1]};
	assign diff  = trial - {1'b0, den_q};
	assign fits  = (trial >= {1'b0, den_q});

	// Step counter and completion flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= DIV_CNT_W'(DIV_NUM_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - DIV_CNT_W'(1);
			if (cnt_q == DIV_CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// The numerator register gradually turns into the quotient.
	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.num;
			rem_q <= '0;
			den_q <= req.den;
		end else if (busy_q) begin
			quo_q <= {quo_q[DIV_NUM_W-2:0], fits};
			rem_q <= fits ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;

endmodule

`default_nettype wire

// File: design/madenv_cfg.sv
// Configuration registers and the sequencer that derives the coefficients and margin.
`default_nettype none

module madenv_cfg import madenv_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  logic [CFG_IDX_W-1:0]  wr_index,
	input  logic [CFG_DATA_W-1:0] wr_data,
	output cfg_bus_t              cfg
);

	logic [CFG_DATA_W-1:0]      attack_q;
	logic [CFG_DATA_W-1:0]      decay_q;
	logic [RATE_W-1:0]          rate_q;
	logic signed [SAMPLE_W-1:0] amp_q;
	logic [ACT_W-1:0]           active_q;
	logic [COEF_W-1:0]          atk_coeff_q;
	logic [COEF_W-1:0]          dec_coeff_q;
	logic [MARGIN_W-1:0]        margin_q;
	logic [DIV_DEN_W-1:0]       den_q;
	drv_state_t                 drv_q;
	drv_state_t                 drv_d;
	div_req_t                   div_req;
	div_rsp_t                   div_rsp;
	logic                       restart;
	logic [RATE_W-1:0]          rate_nz;
	logic [CFG_DATA_W-1:0]      atk_cnt;
	logic [CFG_DATA_W-1:0]      dec_cnt;
	logic [CFG_DATA_W+4:0]      atk_x18;

	// Register writes; a write of a time or of the rate reruns the derivation.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attack_q <= ATTACK_RST;
			decay_q  <= DECAY_RST;
			rate_q   <= RATE_RST;
			amp_q    <= AMP_RST;
			active_q <= ACTIVE_RST;
		end else if (wr_en) begin
			case (wr_index)
				REG_ATTACK: attack_q <= wr_data;
				REG_DECAY:  decay_q  <= wr_data;
				REG_RATE:   rate_q   <= wr_data[RATE_W-1:0];
				REG_AMP:    amp_q    <= $signed(wr_data[SAMPLE_W-1:0]);
				REG_ACTIVE: active_q <= wr_data[ACT_W-1:0];
				default: ;
			endcase
		end
	end

	assign restart = wr_en && (wr_index == REG_ATTACK || wr_index == REG_DECAY ||
		wr_index == REG_RATE);

	// Divider operands: coefficient counts floored at the minimum, a zero rate taken as one.
	assign rate_nz = (rate_q == '0) ? RATE_W'(1) : rate_q;
	assign atk_cnt = (attack_q < CFG_DATA_W'(MIN_COUNT)) ? CFG_DATA_W'(MIN_COUNT) : attack_q;
	assign dec_cnt = (decay_q < CFG_DATA_W'(MIN_COUNT)) ? CFG_DATA_W'(MIN_COUNT) : decay_q;
	assign atk_x18 = {1'b0, attack_q, 4'b0000} + {4'b0000, attack_q, 1'b0};

	// Sequencer state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drv_q <= DRV_SETUP;
		end else begin
			drv_q <= drv_d;
		end
	end

	// Sequencer: attack coefficient, decay coefficient, then margin.
	always_comb begin
		drv_d         = drv_q;
		div_req.start = 1'b0;
		div_req.num   = '0;
		div_req.den   = '0;
		case (drv_q)
			DRV_IDLE: ;
			DRV_SETUP: drv_d = DRV_ATK_GO;
			DRV_ATK_GO: begin
				div_req.start = 1'b1;
				div_req.num   = DIV_NUM_W'(COEF_NUM) + DIV_NUM_W'(atk_cnt >> 1);
				div_req.den   = DIV_DEN_W'(atk_cnt);
				drv_d         = DRV_ATK_WAIT;
			end
			DRV_ATK_WAIT: if (div_rsp.done) drv_d = DRV_DEC_GO;
			DRV_DEC_GO: begin
				div_req.start = 1'b1;
				div_req.num   = DIV_NUM_W'(COEF_NUM) + DIV_NUM_W'(dec_cnt >> 1);
				div_req.den   = DIV_DEN_W'(dec_cnt);
				drv_d         = DRV_DEC_WAIT;
			end
			DRV_DEC_WAIT: if (div_rsp.done) drv_d = DRV_MRG_GO;
			DRV_MRG_GO: begin
				div_req.start = 1'b1;
				div_req.num   = DIV_NUM_W'({atk_x18, {FRAC_W{1'b0}}}) +
					DIV_NUM_W'(den_q >> 1);
				div_req.den   = den_q;
				drv_d         = DRV_MRG_WAIT;
			end
			DRV_MRG_WAIT: if (div_rsp.done) drv_d = DRV_IDLE;
			default: drv_d = DRV_IDLE;
		endcase
		if (restart) begin
			drv_d = DRV_SETUP;
		end
	end

	// Derived values are captured as each division completes.
	always_ff @(posedge clk) begin
		if (drv_q == DRV_SETUP) begin
			den_q <= DIV_DEN_W'(rate_nz) * DIV_DEN_W'(RATE_SCALE);
		end
		if (drv_q == DRV_ATK_WAIT && div_rsp.done) begin
			atk_coeff_q <= div_rsp.quo[COEF_W-1:0];
		end
		if (drv_q == DRV_DEC_WAIT && div_rsp.done) begin
			dec_coeff_q <= div_rsp.quo[COEF_W-1:0];
		end
		if (drv_q == DRV_MRG_WAIT && div_rsp.done) begin
			margin_q <= (div_rsp.quo > DIV_NUM_W'(MARGIN_MAX)) ? MARGIN_MAX :
				div_rsp.quo[MARGIN_W-1:0];
		end
	end

	madenv_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign cfg.amp       = amp_q;
	assign cfg.active    = active_q;
	assign cfg.atk_coeff = atk_coeff_q;
	assign cfg.dec_coeff = dec_coeff_q;
	assign cfg.margin    = margin_q;
	assign cfg.busy      = (drv_q != DRV_IDLE);

endmodule

`default_nettype wire

// File: design/madenv_core.sv
// Channel state memory with a read-modify-write envelope datapath and output register.
`default_nettype none

module madenv_core import madenv_pkg::*; #(
	parameter int MAX_CHANNELS = 16
) (
	input  logic     clk,
	input  logic     arst_n,
	input  cfg_bus_t cfg,
	madenv_tick_if.sink     tick,
	madenv_result_if.source result
);

	localparam int CH_AW  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
	localparam int OP_W   = SAMPLE_W + 1;
	localparam int PROD_W = OP_W + COEF_W + 1;
	localparam int STEP_W = PROD_W - COEF_FRAC;
	localparam int SUM_W  = STEP_W + 1;
	localparam int THR_W  = SAMPLE_W + 11;
	localparam int K_W    = SAMPLE_W + 2;
	localparam int CMP_W  = K_W + 11;
	localparam int AMP_W  = 2 * SAMPLE_W;
	localparam int Y_W    = AMP_W - FRAC_W;

	localparam logic signed [PROD_W-1:0] COEF_HALF = PROD_W'(1 << (COEF_FRAC - 1));
	localparam logic signed [SUM_W-1:0]  LVL_MAX   = SUM_W'((1 << (SAMPLE_W - 1)) - 1);
	localparam logic signed [SUM_W-1:0]  LVL_MIN   = SUM_W'(-(1 << (SAMPLE_W - 1)));
	localparam logic signed [THR_W-1:0]  THR_MUL   = THR_W'(THR_NUM);
	localparam logic signed [THR_W-1:0]  THR_ADD   = THR_W'(THR_HALF);
	localparam logic signed [CMP_W-1:0]  CMP_MUL   = CMP_W'(THR_DEN);
	localparam logic signed [AMP_W-1:0]  AMP_HALF  = AMP_W'(1 << (FRAC_W - 1));
	localparam logic signed [Y_W-1:0]    Y_ONE     = Y_W'(1 << FRAC_W);

	core_state_t                state_q;
	core_state_t                state_d;
	chan_state_t                mem [MAX_CHANNELS];
	logic [MAX_CHANNELS-1:0]    written_q;

	logic                       accept;
	logic                       active;
	logic [CH_AW-1:0]           in_addr;

	// Item registers and first stage
	logic [CH_AW-1:0]           addr_q;
	logic [CHAN_W-1:0]          chan_q;
	logic                       gate_q;
	logic signed [SAMPLE_W-1:0] velo_q;
	chan_state_t                rd_s1;
	logic                       rd_vld_s1;
	chan_state_t                cur;
	logic                       rise;
	logic                       attack;
	logic signed [SAMPLE_W-1:0] tgt;
	logic signed [OP_W-1:0]     op;
	logic [COEF_W-1:0]          coeff;
	logic signed [PROD_W-1:0]   prod;

	// Second stage
	logic signed [PROD_W-1:0]   prod_s2;
	logic signed [SAMPLE_W-1:0] lvl_s2;
	logic signed [SAMPLE_W-1:0] tgt_s2;
	logic                       attack_s2;
	logic                       gate_s2;
	logic signed [PROD_W-1:0]   prod_rnd;
	logic signed [STEP_W-1:0]   step;
	logic signed [SUM_W-1:0]    lvl_ext;
	logic signed [SUM_W-1:0]    step_ext;
	logic signed [SUM_W-1:0]    sum;
	logic signed [SAMPLE_W-1:0] lvl_new;
	logic signed [THR_W-1:0]    thr;

	// Third stage
	logic signed [SAMPLE_W-1:0] lvl_s3;
	logic signed [SAMPLE_W-1:0] tgt_s3;
	logic                       attack_s3;
	logic                       gate_s3;
	logic signed [THR_W-1:0]    thr_s3;
	logic signed [K_W-1:0]      k1;
	logic signed [CMP_W-1:0]    k1_x1000;
	logic                       reached;
	chan_state_t                wr_entry;
	logic signed [AMP_W-1:0]    amp_prod;
	logic                       wb_go;

	// Finishing stage and output register
	logic signed [AMP_W-1:0]    prod_s4;
	logic [CHAN_W-1:0]          chan_s4;
	logic                       fin_q;
	logic signed [AMP_W-1:0]    y_rnd;
	logic signed [Y_W-1:0]      y;
	logic signed [OUT_W-1:0]    y_clip;
	logic                       out_load;
	logic                       out_valid_q;
	logic [CHAN_W-1:0]          out_chan_q;
	logic signed [OUT_W-1:0]    out_env_q;

	// Items for channels out of use are taken and dropped.
	assign accept  = tick.valid && tick.ready;
	assign active  = ({1'b0, tick.channel} < cfg.active) &&
		(32'(tick.channel) < 32'(MAX_CHANNELS));
	assign in_addr = CH_AW'(tick.channel);

	// Sequencer state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CS_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// One item at a time: read, multiply, update, write back.
	always_comb begin
		state_d    = state_q;
		tick.ready = 1'b0;
		case (state_q)
			CS_IDLE: begin
				tick.ready = !cfg.busy;
				if (accept && active) begin
					state_d = CS_MUL;
				end
			end
			CS_MUL: state_d = CS_UPD;
			CS_UPD: state_d = CS_WB;
			CS_WB: if (wb_go) state_d = CS_IDLE;
			default: state_d = CS_IDLE;
		endcase
	end

	// Channel state memory: read on accept, write back at the end of the item.
	always_ff @(posedge clk) begin
		if (accept && active) begin
			rd_s1     <= mem[in_addr];
			rd_vld_s1 <= written_q[in_addr];
		end
		if (wb_go) begin
			mem[addr_q] <= wr_entry;
		end
	end

	// An entry never written reads as the reset state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q <= '0;
		end else if (wb_go) begin
			written_q[addr_q] <= 1'b1;
		end
	end

	// Item fields are held for the whole item.
	always_ff @(posedge clk) begin
		if (accept && active) begin
			addr_q <= in_addr;
			chan_q <= tick.channel;
			gate_q <= tick.gate;
			velo_q <= tick.velocity;
		end
	end

	// Gate edge detection and the coefficient multiply.
	assign cur    = rd_vld_s1 ? rd_s1 : CHAN_RESET;
	assign rise   = !cur.prev_gate && gate_q;
	assign attack = rise || !cur.in_decay;
	assign tgt    = rise ? velo_q : cur.held;
	assign op     = attack ? ({tgt[SAMPLE_W-1], tgt} - {cur.level[SAMPLE_W-1], cur.level})
		: {cur.level[SAMPLE_W-1], cur.level};
	assign coeff  = attack ? cfg.atk_coeff : cfg.dec_coeff;
	assign prod   = op * $signed({1'b0, coeff});

	always_ff @(posedge clk) begin
		if (state_q == CS_MUL) begin
			prod_s2   <= prod;
			lvl_s2    <= cur.level;
			tgt_s2    <= tgt;
			attack_s2 <= attack;
			gate_s2   <= gate_q;
		end
	end

	// Round the step, apply it and saturate; scale the target for the threshold.
	assign prod_rnd = prod_s2 + COEF_HALF;
	assign step     = prod_rnd[PROD_W-1:COEF_FRAC];
	assign lvl_ext  = {{(SUM_W - SAMPLE_W){lvl_s2[SAMPLE_W-1]}}, lvl_s2};
	assign step_ext = {step[STEP_W-1], step};
	assign sum      = attack_s2 ? (lvl_ext + step_ext) : (lvl_ext - step_ext);
	assign lvl_new  = (sum > LVL_MAX) ? LVL_MAX[SAMPLE_W-1:0] :
		(sum < LVL_MIN) ? LVL_MIN[SAMPLE_W-1:0] : sum[SAMPLE_W-1:0];
	assign thr      = {{(THR_W - SAMPLE_W){tgt_s2[SAMPLE_W-1]}}, tgt_s2} * THR_MUL + THR_ADD;

	always_ff @(posedge clk) begin
		if (state_q == CS_UPD) begin
			lvl_s3    <= lvl_new;
			tgt_s3    <= tgt_s2;
			attack_s3 <= attack_s2;
			gate_s3   <= gate_s2;
			thr_s3    <= thr;
		end
	end

	// The attack ends once level + margin reaches the rounded 0.999 target,
	// tested without a divide as 1000 * (level + margin + 1) > 999 * target + 500.
	assign k1       = {{(K_W - SAMPLE_W){lvl_s3[SAMPLE_W-1]}}, lvl_s3} +
		{{(K_W - MARGIN_W){1'b0}}, cfg.margin} + K_W'(1);
	assign k1_x1000 = {{(CMP_W - K_W){k1[K_W-1]}}, k1} * CMP_MUL;
	assign reached  = (k1_x1000 > $signed({{(CMP_W - THR_W){thr_s3[THR_W-1]}}, thr_s3}));

	assign wr_entry.level     = lvl_s3;
	assign wr_entry.held      = tgt_s3;
	assign wr_entry.in_decay  = !attack_s3 || reached;
	assign wr_entry.prev_gate = gate_s3;

	assign amp_prod = cfg.amp * lvl_s3;
	assign wb_go    = (state_q == CS_WB) && (!fin_q || out_load);

	always_ff @(posedge clk) begin
		if (wb_go) begin
			prod_s4 <= amp_prod;
			chan_s4 <= chan_q;
		end
	end

	// Round the scaled level and clip it to plus or minus one.
	assign y_rnd  = prod_s4 + AMP_HALF;
	assign y      = y_rnd[AMP_W-1:FRAC_W];
	assign y_clip = (y > Y_ONE) ? Y_ONE[OUT_W-1:0] :
		(y < -Y_ONE) ? OUT_W'(-Y_ONE) : y[OUT_W-1:0];

	assign out_load = fin_q && (!out_valid_q || result.ready);

	// Finishing stage and output register form a two-item buffer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fin_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (wb_go) begin
				fin_q <= 1'b1;
			end else if (out_load) begin
				fin_q <= 1'b0;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_chan_q <= chan_s4;
			out_env_q  <= y_clip;
		end
	end

	assign result.valid        = out_valid_q;
	assign result.out_channel  = out_chan_q;
	assign result.envelope_out = out_env_q;

endmodule

`default_nettype wire

// File: design/madenv_checker.sv
// Port-level checks of the envelope unit and their binding to the top level.
`default_nettype none

module madenv_checker import madenv_pkg::*; (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    tick_ready,
	input logic                    result_valid,
	input logic                    result_ready,
	input logic [CHAN_W-1:0]       out_channel,
	input logic signed [OUT_W-1:0] envelope_out,
	input logic                    wr_en,
	input logic [CFG_IDX_W-1:0]    wr_index
);

	localparam logic signed [OUT_W-1:0] OUT_ONE = OUT_W'(1 << FRAC_W);

	// Coefficients are rederived after reset, so no tick is taken straight away.
	a_reset_busy: assert property (@(posedge clk) !arst_n |=> !tick_ready)
		else $error("tick taken right after reset");

	// A new time or rate blocks ticks while the coefficients are recomputed.
	a_cfg_busy: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en && (wr_index == REG_ATTACK || wr_index == REG_DECAY || wr_index == REG_RATE)
		|=> !tick_ready)
		else $error("tick ready during coefficient derivation");

	// A result that is not taken stays as it is.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(envelope_out) &&
		$stable(out_channel))
		else $error("stalled result changed");

	// The output never leaves the clipping range.
	a_clip: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (envelope_out <= OUT_ONE) && (envelope_out >= -OUT_ONE))
		else $error("envelope outside plus or minus one");

endmodule

bind multichannel_attack_decay_envelope_unit madenv_checker u_madenv_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.tick_ready   (tick.ready),
	.result_valid (result.valid),
	.result_ready (result.ready),
	.out_channel  (result.out_channel),
	.envelope_out (result.envelope_out),
	.wr_en        (wr_en),
	.wr_index     (wr_index)
);

`default_nettype wire
